// ===== design/euler_to_rotation_matrix_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef EULER_TO_ROTATION_MATRIX_MACROS_SVH
`define EULER_TO_ROTATION_MATRIX_MACROS_SVH

// Checked on every edge except while reset is high.
`define E2R_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define E2R_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/e2r_pkg.sv =====
package e2r_pkg;

   // default sizes
   localparam int ANGLE_BITS_DEF   = 16;
   localparam int COEF_BITS_DEF    = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   // internal datapath: Q30 values, 32-bit angle unit (2^31 = pi)
   localparam int DW   = 32;
   localparam int FRAC = 30;
   localparam int MAT_N = 9;

   // CORDIC start vector: inverse of the limit gain, in Q30
   localparam logic signed [DW-1:0] GAIN_Q30 = 32'sd652032875;
   localparam logic signed [DW-1:0] QUARTER  = 32'sd1073741824;

   // atan(2^-i) in the 32-bit angle unit
   localparam logic signed [DW-1:0] ATAN_TAB [32] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
      32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81,
      32'sd41,        32'sd20,        32'sd10,        32'sd5,
      32'sd3,         32'sd1,         32'sd1,         32'sd0
   };

   // matrix element positions in the result word
   localparam int R00 = 0;
   localparam int R01 = 1;
   localparam int R02 = 2;
   localparam int R10 = 3;
   localparam int R11 = 4;
   localparam int R12 = 5;
   localparam int R20 = 6;
   localparam int R21 = 7;
   localparam int R22 = 8;

endpackage

// ===== design/e2r_req_if.sv =====
interface e2r_req_if #(
   parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS-1:0] roll_angle;
   logic signed [ANGLE_BITS-1:0] pitch_angle;
   logic signed [ANGLE_BITS-1:0] yaw_angle;

   modport source (output valid, output roll_angle, output pitch_angle,
                   output yaw_angle, input ready);
   modport sink   (input valid, input roll_angle, input pitch_angle,
                   input yaw_angle, output ready);
endinterface

// ===== design/e2r_rsp_if.sv =====
interface e2r_rsp_if #(
   parameter int COEF_BITS = e2r_pkg::COEF_BITS_DEF
);
   logic                        valid;
   logic                        ready;
   logic signed [COEF_BITS-1:0] r00;
   logic signed [COEF_BITS-1:0] r01;
   logic signed [COEF_BITS-1:0] r02;
   logic signed [COEF_BITS-1:0] r10;
   logic signed [COEF_BITS-1:0] r11;
   logic signed [COEF_BITS-1:0] r12;
   logic signed [COEF_BITS-1:0] r20;
   logic signed [COEF_BITS-1:0] r21;
   logic signed [COEF_BITS-1:0] r22;

   modport source (output valid, output r00, output r01, output r02,
                   output r10, output r11, output r12, output r20,
                   output r21, output r22, input ready);
   modport sink   (input valid, input r00, input r01, input r02,
                   input r10, input r11, input r12, input r20,
                   input r21, input r22, output ready);
endinterface

// ===== design/e2r_cordic_lane.sv =====
module e2r_cordic_lane #(
   parameter int ANGLE_BITS   = e2r_pkg::ANGLE_BITS_DEF,
   parameter int CORDIC_STEPS = e2r_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic        [ANGLE_BITS-1:0]      angle,
   output logic signed [e2r_pkg::DW-1:0]     sin_q,
   output logic signed [e2r_pkg::DW-1:0]     cos_q
);
   localparam int UP = e2r_pkg::DW - ANGLE_BITS;

   logic        [e2r_pkg::DW-1:0] ang_u;
   logic signed [e2r_pkg::DW-1:0] ang_s;
   logic                          big;
   logic        [e2r_pkg::DW-1:0] ang_r;

   logic signed [e2r_pkg::DW-1:0] x_ff [CORDIC_STEPS];
   logic signed [e2r_pkg::DW-1:0] y_ff [CORDIC_STEPS];
   logic signed [e2r_pkg::DW-1:0] z_ff [CORDIC_STEPS];
   logic                          flip_ff [CORDIC_STEPS];

   // scale to the 32-bit angle unit, fold outer half-plane by pi
   always_comb begin
      ang_u = e2r_pkg::DW'(angle) << UP;
      ang_s = signed'(ang_u);
      big   = (ang_s > e2r_pkg::QUARTER) || (ang_s < -e2r_pkg::QUARTER);
      ang_r = big ? {~ang_u[e2r_pkg::DW-1], ang_u[e2r_pkg::DW-2:0]} : ang_u;
   end

   for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
      logic signed [e2r_pkg::DW-1:0] xi, yi, zi;
      logic                          fi;
      logic signed [e2r_pkg::DW-1:0] x_in, y_in, z_in;

      if (s == 0) begin : g_first
         assign xi = e2r_pkg::GAIN_Q30;
         assign yi = '0;
         assign zi = signed'(ang_r);
         assign fi = big;
      end else begin : g_next
         assign xi = x_ff[s-1];
         assign yi = y_ff[s-1];
         assign zi = z_ff[s-1];
         assign fi = flip_ff[s-1];
      end

      always_comb begin
         if (zi >= 0) begin
            x_in = xi - (yi >>> s);
            y_in = yi + (xi >>> s);
            z_in = zi - e2r_pkg::ATAN_TAB[s];
         end else begin
            x_in = xi + (yi >>> s);
            y_in = yi - (xi >>> s);
            z_in = zi + e2r_pkg::ATAN_TAB[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[s]    <= x_in;
            y_ff[s]    <= y_in;
            z_ff[s]    <= z_in;
            flip_ff[s] <= fi;
         end
      end
   end

   assign sin_q = flip_ff[CORDIC_STEPS-1] ? -y_ff[CORDIC_STEPS-1] : y_ff[CORDIC_STEPS-1];
   assign cos_q = flip_ff[CORDIC_STEPS-1] ? -x_ff[CORDIC_STEPS-1] : x_ff[CORDIC_STEPS-1];

endmodule

// ===== design/e2r_mat_merge.sv =====
module e2r_mat_merge #(
   parameter int COEF_BITS = e2r_pkg::COEF_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       en,
   input  logic signed [e2r_pkg::DW-1:0]              sx,
   input  logic signed [e2r_pkg::DW-1:0]              cx,
   input  logic signed [e2r_pkg::DW-1:0]              sy,
   input  logic signed [e2r_pkg::DW-1:0]              cy,
   input  logic signed [e2r_pkg::DW-1:0]              sz,
   input  logic signed [e2r_pkg::DW-1:0]              cz,
   output logic [e2r_pkg::MAT_N-1:0][COEF_BITS-1:0]   mat
);
   localparam int SH = e2r_pkg::FRAC - (COEF_BITS - 2);
   localparam logic signed [35:0] RND = 36'((64'sd1 << SH) >> 1);
   localparam logic signed [35:0] ONE = 36'sd1 <<< (COEF_BITS - 2);

   // Q30 x Q30 product, rounded half up back to Q30
   function automatic logic signed [e2r_pkg::DW-1:0] qmul(
      input logic signed [e2r_pkg::DW-1:0] a,
      input logic signed [e2r_pkg::DW-1:0] b
   );
      logic signed [63:0] p;
      p = a * b;
      return e2r_pkg::DW'((p + 64'sd536870912) >>> e2r_pkg::FRAC);
   endfunction

   // round to the output fraction and clamp to +/-1.0
   function automatic logic [COEF_BITS-1:0] to_out(input logic signed [33:0] v);
      logic signed [35:0] r;
      r = (36'(v) + RND) >>> SH;
      if (r > ONE)  r = ONE;
      if (r < -ONE) r = -ONE;
      return COEF_BITS'(r);
   endfunction

   // first product rank
   logic signed [e2r_pkg::DW-1:0] czsy_ff, szsy_ff, czcy_ff, szcx_ff, szsx_ff;
   logic signed [e2r_pkg::DW-1:0] szcy_ff, czcx_ff, czsx_ff, cysx_ff, cycx_ff;
   logic signed [e2r_pkg::DW-1:0] sx1_ff, cx1_ff, sy1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         czsy_ff <= qmul(cz, sy);
         szsy_ff <= qmul(sz, sy);
         czcy_ff <= qmul(cz, cy);
         szcx_ff <= qmul(sz, cx);
         szsx_ff <= qmul(sz, sx);
         szcy_ff <= qmul(sz, cy);
         czcx_ff <= qmul(cz, cx);
         czsx_ff <= qmul(cz, sx);
         cysx_ff <= qmul(cy, sx);
         cycx_ff <= qmul(cy, cx);
         sx1_ff  <= sx;
         cx1_ff  <= cx;
         sy1_ff  <= sy;
      end
   end

   // second rank: three-factor terms, the rest carried along
   logic signed [e2r_pkg::DW-1:0] t01_ff, t02_ff, t11_ff, t12_ff;
   logic signed [e2r_pkg::DW-1:0] szcx2_ff, szsx2_ff, czcx2_ff, czsx2_ff;
   logic signed [e2r_pkg::DW-1:0] czcy2_ff, szcy2_ff, cysx2_ff, cycx2_ff, sy2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t01_ff   <= qmul(czsy_ff, sx1_ff);
         t02_ff   <= qmul(czsy_ff, cx1_ff);
         t11_ff   <= qmul(szsy_ff, sx1_ff);
         t12_ff   <= qmul(szsy_ff, cx1_ff);
         szcx2_ff <= szcx_ff;
         szsx2_ff <= szsx_ff;
         czcx2_ff <= czcx_ff;
         czsx2_ff <= czsx_ff;
         czcy2_ff <= czcy_ff;
         szcy2_ff <= szcy_ff;
         cysx2_ff <= cysx_ff;
         cycx2_ff <= cycx_ff;
         sy2_ff   <= sy1_ff;
      end
   end

   // final sums and output formatting
   always_comb begin
      mat[e2r_pkg::R00] = to_out(34'(czcy2_ff));
      mat[e2r_pkg::R01] = to_out(34'(t01_ff) - 34'(szcx2_ff));
      mat[e2r_pkg::R02] = to_out(34'(t02_ff) + 34'(szsx2_ff));
      mat[e2r_pkg::R10] = to_out(34'(szcy2_ff));
      mat[e2r_pkg::R11] = to_out(34'(t11_ff) + 34'(czcx2_ff));
      mat[e2r_pkg::R12] = to_out(34'(t12_ff) - 34'(czsx2_ff));
      mat[e2r_pkg::R20] = to_out(-34'(sy2_ff));
      mat[e2r_pkg::R21] = to_out(34'(cysx2_ff));
      mat[e2r_pkg::R22] = to_out(34'(cycx2_ff));
   end

endmodule

// ===== design/e2r_out_buf.sv =====
module e2r_out_buf #(
   parameter int COEF_BITS = e2r_pkg::COEF_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     push,
   input  logic [e2r_pkg::MAT_N-1:0][COEF_BITS-1:0] mat,
   output logic                                     room,
   e2r_rsp_if.source                                rsp_ch
);
   logic [e2r_pkg::MAT_N-1:0][COEF_BITS-1:0] mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;
   logic [e2r_pkg::MAT_N-1:0][COEF_BITS-1:0] head;

   assign pop  = rsp_ch.valid && rsp_ch.ready;
   assign room = (cnt_ff != 2'd2);

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= mat;
      end
   end

   assign head         = mem_ff[rd_ff];
   assign rsp_ch.valid = (cnt_ff != 2'd0);
   assign rsp_ch.r00   = head[e2r_pkg::R00];
   assign rsp_ch.r01   = head[e2r_pkg::R01];
   assign rsp_ch.r02   = head[e2r_pkg::R02];
   assign rsp_ch.r10   = head[e2r_pkg::R10];
   assign rsp_ch.r11   = head[e2r_pkg::R11];
   assign rsp_ch.r12   = head[e2r_pkg::R12];
   assign rsp_ch.r20   = head[e2r_pkg::R20];
   assign rsp_ch.r21   = head[e2r_pkg::R21];
   assign rsp_ch.r22   = head[e2r_pkg::R22];

endmodule

// ===== design/euler_to_rotation_matrix.sv =====
// Roll/pitch/yaw to Z-Y-X rotation matrix, R = Rz(yaw) * Ry(pitch) * Rx(roll).
// req_ch: one word carries roll, pitch and yaw as signed binary angles, full
//   scale = +/-pi. A word is taken on any edge with valid and ready high.
// rsp_ch: one word per request, the nine matrix elements r00..r22 in signed
//   Q2.14 (COEF_BITS-2 fraction bits), clamped to +/-1.0. Same order as input.
// Throughput: one word per cycle, back to back, while the output buffer has room.
// Pipeline: from accept to rsp valid a word passes the CORDIC_STEPS rotator
//   stages, two product ranks, then the output buffer.
// Stall: the pipe moves as one; a two-word output buffer sits after it, so
//   with one word waiting on the consumer a new request is still taken. The
//   pipe freezes (req ready low) only when both buffer slots are full.
// Reset: synchronous, active high; drops all in-flight words and empties the
//   output buffer. No clearing pass, no stored state between words.
`include "euler_to_rotation_matrix_macros.svh"

module euler_to_rotation_matrix #(
   parameter int ANGLE_BITS   = e2r_pkg::ANGLE_BITS_DEF,
   parameter int COEF_BITS    = e2r_pkg::COEF_BITS_DEF,
   parameter int CORDIC_STEPS = e2r_pkg::CORDIC_STEPS_DEF
) (
   input logic       clock,
   input logic       reset,
   e2r_req_if.sink   req_ch,
   e2r_rsp_if.source rsp_ch
);
   // stages tracked: rotator stages plus two product ranks
   localparam int NST = CORDIC_STEPS + 2;

   logic           en;        // whole pipe advances
   logic           acc;       // request taken this edge
   logic           push;      // last stage word enters the buffer
   logic [NST-1:0] vld_ff, vld_in;

   logic signed [e2r_pkg::DW-1:0] sx, cx, sy, cy, sz, cz;
   logic [e2r_pkg::MAT_N-1:0][COEF_BITS-1:0] mat;

   assign req_ch.ready = en;
   assign acc          = req_ch.valid && en;
   assign push         = en && vld_ff[NST-1];

   // occupancy shift line, moves with the datapath
   always_comb begin
      vld_in = {vld_ff[NST-2:0], acc};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // three rotator lanes side by side, one per axis
   e2r_cordic_lane #(
      .ANGLE_BITS  (ANGLE_BITS),
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_lane_roll (
      .clock(clock),
      .en   (en),
      .angle(req_ch.roll_angle),
      .sin_q(sx),
      .cos_q(cx)
   );

   e2r_cordic_lane #(
      .ANGLE_BITS  (ANGLE_BITS),
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_lane_pitch (
      .clock(clock),
      .en   (en),
      .angle(req_ch.pitch_angle),
      .sin_q(sy),
      .cos_q(cy)
   );

   e2r_cordic_lane #(
      .ANGLE_BITS  (ANGLE_BITS),
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_lane_yaw (
      .clock(clock),
      .en   (en),
      .angle(req_ch.yaw_angle),
      .sin_q(sz),
      .cos_q(cz)
   );

   // combine the lane outputs into the nine elements
   e2r_mat_merge #(
      .COEF_BITS(COEF_BITS)
   ) u_merge (
      .clock(clock),
      .en   (en),
      .sx   (sx),
      .cx   (cx),
      .sy   (sy),
      .cy   (cy),
      .sz   (sz),
      .cz   (cz),
      .mat  (mat)
   );

   // two-word buffer decouples the consumer from the pipe
   e2r_out_buf #(
      .COEF_BITS(COEF_BITS)
   ) u_out_buf (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .mat   (mat),
      .room  (en),
      .rsp_ch(rsp_ch)
   );

   `E2R_ASSERT(a_acc_enters, clock, reset, acc |=> vld_ff[0], "accepted word lost at entry")
   `E2R_ASSERT(a_freeze_holds, clock, reset, !en |=> $stable(vld_ff), "pipe moved while frozen")
   `E2R_ASSERT(a_push_shows, clock, reset, push |=> rsp_ch.valid, "pushed word not presented")

endmodule

// ===== dv/euler_to_rotation_matrix_tb.sv =====
`timescale 1ns / 100ps

module euler_to_rotation_matrix_tb;

   // ---------------------------------------------------------------------
   // Types and run constants
   // ---------------------------------------------------------------------
   typedef struct packed {
      logic [15:0] roll;
      logic [15:0] pitch;
      logic [15:0] yaw;
   } angles_type;

   // nine Q2.14 elements, indexed by the package positions R00..R22
   typedef logic [e2r_pkg::MAT_N-1:0][15:0] matrix_type;

   localparam int     RANDOM_WORDS = 850;
   localparam int     SQUEEZE_AT   = 250;     // words seen before the long hold-off
   localparam int     SQUEEZE_LEN  = 300;     // cycles the consumer holds off
   localparam int     DRAIN_CYCLES = 40;      // idle cycles after the scoreboard empties
   localparam int     CYCLE_LIMIT  = 500000;

   // CORDIC constants: Q30 start vector, angles in the 2^31 = pi unit
   localparam int     STEPS        = 16;
   localparam longint CORDIC_GAIN  = 64'sd652032875;
   localparam longint QUARTER_TURN = 64'sd1073741824;
   localparam longint ARC_STEP [STEPS] = '{
      64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
      64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340245,
      64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
      64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861
   };

   // zero angles, or all three at -pi, give the identity matrix
   localparam matrix_type IDENTITY = {16'd16384, 16'd0, 16'd0,
                                      16'd0, 16'd16384, 16'd0,
                                      16'd0, 16'd0, 16'd16384};

   string ELEM_NAMES [e2r_pkg::MAT_N] = '{"r00", "r01", "r02", "r10", "r11", "r12",
                                          "r20", "r21", "r22"};

   // ---------------------------------------------------------------------
   // Clock, reset, channels, block
   // ---------------------------------------------------------------------
   logic clock;
   logic reset;

   e2r_req_if req_ch ();
   e2r_rsp_if rsp_ch ();

   euler_to_rotation_matrix u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Scoreboard state
   // ---------------------------------------------------------------------
   matrix_type pending_matrices [$];   // expected words, oldest first
   angles_type directed_rows [$];      // directed stimulus table
   bit         directed_typed [$];     // row carries a typed-in identity result
   int         mismatches    = 0;
   int         words_checked = 0;
   int         cycle_count   = 0;

   // ---------------------------------------------------------------------
   // Predictor: CORDIC sine/cosine, Q30 products, Q2.14 output
   // ---------------------------------------------------------------------
   function automatic void sin_cos_of(input logic [15:0] ang,
                                      output longint sin_q, output longint cos_q);
      logic [31:0] turn;
      longint      z, x, y, dx, dy;
      bit          flip;
      turn = {ang, 16'h0000};
      z    = longint'($signed(turn));
      // past +/-pi/2: rotate by pi, run CORDIC, negate both outputs
      flip = (z > QUARTER_TURN) || (z < -QUARTER_TURN);
      if (flip) begin
         turn = turn + 32'h8000_0000;
         z    = longint'($signed(turn));
      end
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ARC_STEP[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ARC_STEP[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      sin_q = y;
      cos_q = x;
   endfunction

   // Q30 x Q30 -> Q30, round half up
   function automatic longint q30_mul(longint a, longint b);
      return (a * b + 64'sd536870912) >>> 30;
   endfunction

   // Q30 -> Q2.14, round half up, clamp to +/-1.0
   function automatic logic [15:0] to_q14(longint v);
      longint r;
      r = (v + 64'sd32768) >>> 16;
      if (r > 16384)  r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
   endfunction

   function automatic matrix_type rotation_from_angles(angles_type a);
      longint     sx, cx, sy, cy, sz, cz, czsy, szsy;
      matrix_type m;
      sin_cos_of(a.roll,  sx, cx);
      sin_cos_of(a.pitch, sy, cy);
      sin_cos_of(a.yaw,   sz, cz);
      czsy   = q30_mul(cz, sy);
      szsy   = q30_mul(sz, sy);
      m[e2r_pkg::R00] = to_q14(q30_mul(cz, cy));
      m[e2r_pkg::R01] = to_q14(q30_mul(czsy, sx) - q30_mul(sz, cx));
      m[e2r_pkg::R02] = to_q14(q30_mul(czsy, cx) + q30_mul(sz, sx));
      m[e2r_pkg::R10] = to_q14(q30_mul(sz, cy));
      m[e2r_pkg::R11] = to_q14(q30_mul(szsy, sx) + q30_mul(cz, cx));
      m[e2r_pkg::R12] = to_q14(q30_mul(szsy, cx) - q30_mul(cz, sx));
      m[e2r_pkg::R20] = to_q14(-sy);
      m[e2r_pkg::R21] = to_q14(q30_mul(cy, sx));
      m[e2r_pkg::R22] = to_q14(q30_mul(cy, cx));
      return m;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic add_row(int roll, int pitch, int yaw, bit typed);
      angles_type a;
      a.roll  = 16'(roll);
      a.pitch = 16'(pitch);
      a.yaw   = 16'(yaw);
      directed_rows.push_back(a);
      directed_typed.push_back(typed);
   endtask

   // angle near zero, the quadrant fold at +/-pi/2, the +/-pi wrap, or random
   function automatic logic [15:0] edge_angle();
      int offs;
      offs = int'($urandom_range(0, 6)) - 3;
      case ($urandom_range(0, 4))
         0:       return 16'(offs);
         1:       return 16'(16384 + offs);
         2:       return 16'(-16384 + offs);
         3:       return 16'(32768 + offs);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic angles_type random_angles();
      angles_type a;
      int         mode;
      mode    = $urandom_range(0, 9);
      a.roll  = 16'($urandom);
      a.pitch = 16'($urandom);
      a.yaw   = 16'($urandom);
      if (mode == 6) begin
         a.pitch = edge_angle();       // edge pitch, gimbal lock neighborhood included
      end else if (mode >= 7) begin
         a.roll  = edge_angle();
         a.pitch = edge_angle();
         a.yaw   = edge_angle();
      end
      return a;
   endfunction

   // idle length: mostly none, some short, a few long; quiet = no idling
   function automatic int pick_idle(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Offer one word on the request side; inputs move on the falling edge,
   // acceptance is seen on the rising edge. The expectation is queued at
   // the accepting edge.
   task automatic drive_word(angles_type a, bit typed, bit quiet);
      int gap;
      gap = pick_idle(quiet);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.roll_angle  <= a.roll;
      req_ch.pitch_angle <= a.pitch;
      req_ch.yaw_angle   <= a.yaw;
      do @(posedge clock); while (!req_ch.ready);
      pending_matrices.push_back(typed ? IDENTITY : rotation_from_angles(a));
   endtask

   // ---------------------------------------------------------------------
   // Timeout
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words pending",
                  cycle_count, pending_matrices.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Response side: random back-pressure plus one long hold-off so the
   // pipe and its two-word output buffer fill and req ready drops.
   // ---------------------------------------------------------------------
   initial begin
      int  stall_left;
      bit  squeezed;
      stall_left   = 0;
      squeezed     = 1'b0;
      rsp_ch.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (!squeezed && words_checked >= SQUEEZE_AT) begin
            rsp_ch.ready <= 1'b0;
            stall_left    = SQUEEZE_LEN - 1;
            squeezed      = 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
            // one window in four, by cycle_count, runs with no stalls
            stall_left    = pick_idle(((cycle_count / 600) % 4) == 3);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Checker: each accepted response word against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      matrix_type got;
      matrix_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got[e2r_pkg::R00] = rsp_ch.r00;
         got[e2r_pkg::R01] = rsp_ch.r01;
         got[e2r_pkg::R02] = rsp_ch.r02;
         got[e2r_pkg::R10] = rsp_ch.r10;
         got[e2r_pkg::R11] = rsp_ch.r11;
         got[e2r_pkg::R12] = rsp_ch.r12;
         got[e2r_pkg::R20] = rsp_ch.r20;
         got[e2r_pkg::R21] = rsp_ch.r21;
         got[e2r_pkg::R22] = rsp_ch.r22;
         if (pending_matrices.size() == 0) begin
            report_mismatch("response word with nothing pending");
         end else begin
            want = pending_matrices.pop_front();
            for (int k = 0; k < e2r_pkg::MAT_N; k++) begin
               if (got[k] !== want[k])
                  report_mismatch($sformatf("word %0d %s got %0d want %0d",
                                  words_checked, ELEM_NAMES[k],
                                  $signed(got[k]), $signed(want[k])));
            end
         end
         words_checked++;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence: reset, directed table, random words, drain, verdict
   // ---------------------------------------------------------------------
   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.roll_angle  = '0;
      req_ch.pitch_angle = '0;
      req_ch.yaw_angle   = '0;

      // Directed table. Typed rows expect the identity; the rest go
      // through the predictor.
      add_row(0, 0, 0, 1'b1);                    // no rotation
      add_row(-32768, -32768, -32768, 1'b1);     // pi about each axis cancels
      add_row(32767, 32767, 32767, 1'b0);        // just under +pi
      add_row(16384, 0, 0, 1'b0);                // exactly +pi/2: no fold
      add_row(-16384, 0, 0, 1'b0);
      add_row(0, 16384, 0, 1'b0);                // gimbal lock
      add_row(0, -16384, 0, 1'b0);
      add_row(0, 0, 16384, 1'b0);
      add_row(0, 0, -16384, 1'b0);
      add_row(16385, -16385, 16383, 1'b0);       // one step either side of the fold
      add_row(-16383, 16385, -16385, 1'b0);
      add_row(-32768, 0, 0, 1'b0);               // -pi folds to zero
      add_row(0, -32768, 0, 1'b0);
      add_row(0, 0, -32768, 1'b0);
      add_row(1, -1, 1, 1'b0);                   // smallest angles
      add_row(-1, 1, -1, 1'b0);
      add_row(32767, 16384, -32768, 1'b0);
      add_row(8192, 8192, 8192, 1'b0);           // 45 degrees
      add_row(-8192, 24576, -24576, 1'b0);
      add_row(12345, -23456, 30000, 1'b0);
      add_row(16384, 16384, 16384, 1'b0);
      add_row(-16384, -16384, -16384, 1'b0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         drive_word(directed_rows[i], directed_typed[i], 1'b0);

      // random part; every third window of 150 words runs back to back
      for (int n = 0; n < RANDOM_WORDS; n++)
         drive_word(random_angles(), 1'b0, ((n / 150) % 3) == 1);

      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (pending_matrices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== euler_to_rotation_matrix.f =====
+incdir+design
design/e2r_pkg.sv
design/e2r_req_if.sv
design/e2r_rsp_if.sv
design/e2r_cordic_lane.sv
design/e2r_mat_merge.sv
design/e2r_out_buf.sv
design/euler_to_rotation_matrix.sv
dv/euler_to_rotation_matrix_tb.sv
